// ----- rtl/core/sdi12ft_pkg.sv -----
// Types, register indexes and constants for the SDI-12 frame transmitter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sdi12ft_pkg;

   localparam int unsigned BreakWidth   = 5;
   localparam int unsigned MarkWidth    = 4;
   localparam int unsigned GapWidth     = 2;
   localparam int unsigned CharWidth    = 7;
   localparam int unsigned CountWidth   = 5;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 5;

   localparam logic [CsrIdxWidth-1:0] RegBreakBits   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegMarkingBits = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegGapBits     = 2'd2;
   localparam logic [CsrIdxWidth-1:0] RegInvert      = 2'd3;

   localparam logic [BreakWidth-1:0] BreakReset = 5'd15;
   localparam logic [MarkWidth-1:0]  MarkReset  = 4'd9;
   localparam logic [GapWidth-1:0]   GapReset   = 2'd1;
   localparam logic                  InvReset   = 1'b1;

   // bit positions within a character frame
   localparam logic [CountWidth-1:0] StartPos  = 5'd0;
   localparam logic [CountWidth-1:0] LastData  = 5'd7;
   localparam logic [CountWidth-1:0] ParityPos = 5'd8;
   localparam logic [CountWidth-1:0] StopPos   = 5'd9;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_BREAK = 3'd1,
      PH_MARK  = 3'd2,
      PH_READY = 3'd3,
      PH_CHAR  = 3'd4,
      PH_GAP   = 3'd5,
      PH_FINAL = 3'd6,
      PH_DONE  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [BreakWidth-1:0] break_bits;
      logic [MarkWidth-1:0]  marking_bits;
      logic [GapWidth-1:0]   gap_bits;
      logic                  invert_output;
   } cfg_type;

   typedef struct packed {
      logic                 wake_request;
      logic                 char_valid;
      logic [CharWidth-1:0] char_value;
      logic                 last_char;
   } req_type;

   typedef struct packed {
      logic pin_level;
      logic drive_enable;
      logic ready_res;
      logic command_done;
   } rsp_type;

endpackage

// ----- rtl/core/sdi12ft_csr.sv -----
// Configuration registers of the SDI-12 frame transmitter.
// Depends on sdi12ft_pkg.
`timescale 1ns / 1ps

module sdi12ft_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sdi12ft_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [sdi12ft_pkg::CsrDataWidth-1:0] csr_wdata,
   output sdi12ft_pkg::cfg_type                 cfg
);

   sdi12ft_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sdi12ft_pkg::RegBreakBits:   cfg_in.break_bits    = csr_wdata;
            sdi12ft_pkg::RegMarkingBits: cfg_in.marking_bits  =
               csr_wdata[sdi12ft_pkg::MarkWidth-1:0];
            sdi12ft_pkg::RegGapBits:     cfg_in.gap_bits      =
               csr_wdata[sdi12ft_pkg::GapWidth-1:0];
            sdi12ft_pkg::RegInvert:      cfg_in.invert_output = csr_wdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.break_bits    <= sdi12ft_pkg::BreakReset;
         cfg_ff.marking_bits  <= sdi12ft_pkg::MarkReset;
         cfg_ff.gap_bits      <= sdi12ft_pkg::GapReset;
         cfg_ff.invert_output <= sdi12ft_pkg::InvReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/sdi12ft_engine.sv -----
// Line sequencer: phase state machine, bit counter, shifter and parity.
// Computes one bit-time result per step. Depends on sdi12ft_pkg.
`timescale 1ns / 1ps

module sdi12ft_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  sdi12ft_pkg::cfg_type cfg,
   input  sdi12ft_pkg::req_type req,
   output sdi12ft_pkg::rsp_type rsp
);

   localparam int unsigned CW = sdi12ft_pkg::CountWidth;

   sdi12ft_pkg::phase_type phase_ff, phase_in, ph;
   logic [CW-1:0]                     count_ff, count_in, cnt, cnt_dec;
   logic [sdi12ft_pkg::CharWidth-1:0] shift_ff, shift_in, shf;
   logic                              par_ff, par_in, par;
   logic                              fin_ff, fin_in, fin;
   logic                              level;
   logic [CW-1:0]                     break_len, mark_len;

   assign break_len = (cfg.break_bits == '0) ? CW'(1) : cfg.break_bits;
   assign mark_len  = (cfg.marking_bits == '0) ? CW'(1) : CW'(cfg.marking_bits);

   // entry transitions taken at the start of the bit time
   always_comb begin
      ph  = phase_ff;
      cnt = count_ff;
      shf = shift_ff;
      par = par_ff;
      fin = fin_ff;
      if (phase_ff == sdi12ft_pkg::PH_IDLE && req.wake_request) begin
         ph  = sdi12ft_pkg::PH_BREAK;
         cnt = break_len;
      end else if (phase_ff == sdi12ft_pkg::PH_READY && req.char_valid) begin
         ph  = sdi12ft_pkg::PH_CHAR;
         cnt = '0;
         shf = req.char_value;
         par = 1'b0;
         fin = req.last_char;
      end
   end

   assign cnt_dec = cnt - CW'(1);

   always_comb begin
      if (cnt == sdi12ft_pkg::StartPos) begin
         level = 1'b0;
      end else if (cnt <= sdi12ft_pkg::LastData) begin
         level = shf[0];
      end else if (cnt == sdi12ft_pkg::ParityPos) begin
         level = par;
      end else begin
         level = 1'b1;
      end
   end

   // next state
   always_comb begin
      phase_in = ph;
      count_in = cnt;
      shift_in = shf;
      par_in   = par;
      fin_in   = fin;
      unique case (ph)
         sdi12ft_pkg::PH_IDLE: ;
         sdi12ft_pkg::PH_BREAK: begin
            count_in = cnt_dec;
            if (cnt_dec == '0) begin
               phase_in = sdi12ft_pkg::PH_MARK;
               count_in = mark_len;
            end
         end
         sdi12ft_pkg::PH_MARK: begin
            count_in = cnt_dec;
            if (cnt_dec == '0) phase_in = sdi12ft_pkg::PH_READY;
         end
         sdi12ft_pkg::PH_READY: ;
         sdi12ft_pkg::PH_CHAR: begin
            if (cnt != sdi12ft_pkg::StartPos && cnt <= sdi12ft_pkg::LastData) begin
               par_in   = par ^ shf[0];
               shift_in = shf >> 1;
            end
            if (cnt >= sdi12ft_pkg::StopPos) begin
               count_in = '0;
               if (fin) begin
                  phase_in = sdi12ft_pkg::PH_FINAL;
               end else if (cfg.gap_bits != '0) begin
                  phase_in = sdi12ft_pkg::PH_GAP;
                  count_in = CW'(cfg.gap_bits);
               end else begin
                  phase_in = sdi12ft_pkg::PH_READY;
               end
            end else begin
               count_in = cnt + CW'(1);
            end
         end
         sdi12ft_pkg::PH_GAP: begin
            count_in = cnt_dec;
            if (cnt_dec == '0) phase_in = sdi12ft_pkg::PH_READY;
         end
         sdi12ft_pkg::PH_FINAL: phase_in = sdi12ft_pkg::PH_DONE;
         sdi12ft_pkg::PH_DONE: begin
            phase_in = sdi12ft_pkg::PH_IDLE;
            fin_in   = 1'b0;
         end
         default: phase_in = sdi12ft_pkg::PH_IDLE;
      endcase
   end

   // result of this bit time
   always_comb begin
      logic lvl;
      lvl = 1'b1;
      rsp.drive_enable = 1'b1;
      rsp.command_done = 1'b0;
      rsp.ready_res    = (phase_ff == sdi12ft_pkg::PH_READY);
      unique case (ph)
         sdi12ft_pkg::PH_IDLE:  rsp.drive_enable = 1'b0;
         sdi12ft_pkg::PH_BREAK: lvl = 1'b0;
         sdi12ft_pkg::PH_MARK,
         sdi12ft_pkg::PH_READY,
         sdi12ft_pkg::PH_GAP,
         sdi12ft_pkg::PH_FINAL: lvl = 1'b1;
         sdi12ft_pkg::PH_CHAR:  lvl = level;
         sdi12ft_pkg::PH_DONE: begin
            rsp.drive_enable = 1'b0;
            rsp.command_done = 1'b1;
         end
         default: rsp.drive_enable = 1'b0;
      endcase
      rsp.pin_level = rsp.drive_enable & (lvl ^ cfg.invert_output);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdi12ft_pkg::PH_IDLE;
         count_ff <= '0;
         shift_ff <= '0;
         par_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         par_ff   <= par_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// ----- rtl/core/sdi12_frame_transmitter.sv -----
// SDI-12 (7E1) frame transmitter top level: request register, sequencer, result register.
// Throughput 1 request per cycle while the result side does not stall, set by the
// single-pass sequencer step between the request and result registers.
// Synchronous active-high reset returns the line to released/idle and loads
// config defaults (break 15, marking 9, gap 1, inverted output).
// Depends on sdi12ft_pkg, sdi12ft_csr, sdi12ft_engine.
`timescale 1ns / 1ps

module sdi12_frame_transmitter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // char_value[6:0], zero pad
   input  logic [1:0]                           req_tuser,  // wake_request, char_valid
   input  logic                                 req_tlast,  // last_char
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // pin_level, drive_enable,
                                                            // ready_res, zero pad
   output logic                                 rsp_tlast,  // command_done
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sdi12ft_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [sdi12ft_pkg::CsrDataWidth-1:0] csr_wdata
);

   sdi12ft_pkg::cfg_type cfg;
   sdi12ft_pkg::req_type req_ff, req_in;
   sdi12ft_pkg::rsp_type rsp_ff, rsp_in;
   logic                 req_valid_ff, rsp_valid_ff;
   logic                 step;

   assign step       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || step;

   assign req_in.wake_request = req_tuser[0];
   assign req_in.char_valid   = req_tuser[1];
   assign req_in.char_value   = req_tdata[sdi12ft_pkg::CharWidth-1:0];
   assign req_in.last_char    = req_tlast;

   sdi12ft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdi12ft_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cfg   (cfg),
      .req   (req_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) req_valid_ff <= req_tvalid;
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) req_ff <= req_in;
      if (step) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.ready_res, rsp_ff.drive_enable, rsp_ff.pin_level};
   assign rsp_tlast  = rsp_ff.command_done;

endmodule

// ----- test/sdi12_frame_transmitter_tb.sv -----
// Self-checking testbench for the SDI-12 7E1 frame transmitter: bit-time ticks in, line state out.
// Predicts every tick with an in-bench line model. Depends on sdi12ft_pkg.
`timescale 1ns / 1ps

module sdi12_frame_transmitter_tb;
   import sdi12ft_pkg::*;

   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   sdi12_frame_transmitter dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   req_type line_ticks[$];
   rsp_type expected_levels[$];
   int mismatches = 0;
   int results_seen = 0;
   int cycles = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int hold_reqs = 0;

   // line model
   cfg_type ln_cfg;
   phase_type ln_phase;
   logic [4:0] ln_count;
   logic [6:0] ln_shift;
   logic ln_parity;
   logic ln_last;

   function automatic rsp_type next_bit_time(req_type r);
      logic lvl, drv, rdy, dn;
      rsp_type o;
      lvl = 1'b1;
      drv = 1'b1;
      rdy = (ln_phase == PH_READY);
      dn = 1'b0;
      if (ln_phase == PH_IDLE && r.wake_request) begin
         ln_phase = PH_BREAK;
         ln_count = (ln_cfg.break_bits == 0) ? 5'd1 : ln_cfg.break_bits;
      end else if (ln_phase == PH_READY && r.char_valid) begin
         ln_phase = PH_CHAR;
         ln_count = StartPos;
         ln_shift = r.char_value;
         ln_parity = 1'b0;
         ln_last = r.last_char;
      end
      case (ln_phase)
         PH_IDLE: drv = 1'b0;
         PH_BREAK: begin
            lvl = 1'b0;
            ln_count = ln_count - 5'd1;
            if (ln_count == 0) begin
               ln_phase = PH_MARK;
               ln_count = (ln_cfg.marking_bits == 0) ? 5'd1 : {1'b0, ln_cfg.marking_bits};
            end
         end
         PH_MARK: begin
            ln_count = ln_count - 5'd1;
            if (ln_count == 0) ln_phase = PH_READY;
         end
         PH_READY: ;
         PH_CHAR: begin
            if (ln_count == StartPos) begin
               lvl = 1'b0;
            end else if (ln_count <= LastData) begin
               lvl = ln_shift[0];
               ln_parity = ln_parity ^ lvl;
               ln_shift = ln_shift >> 1;
            end else if (ln_count == ParityPos) begin
               lvl = ln_parity;
            end
            if (ln_count >= StopPos) begin
               ln_count = '0;
               if (ln_last) begin
                  ln_phase = PH_FINAL;
               end else if (ln_cfg.gap_bits != 0) begin
                  ln_phase = PH_GAP;
                  ln_count = {3'b0, ln_cfg.gap_bits};
               end else begin
                  ln_phase = PH_READY;
               end
            end else begin
               ln_count = ln_count + 5'd1;
            end
         end
         PH_GAP: begin
            ln_count = ln_count - 5'd1;
            if (ln_count == 0) ln_phase = PH_READY;
         end
         PH_FINAL: ln_phase = PH_DONE;
         default: begin
            drv = 1'b0;
            dn = 1'b1;
            ln_phase = PH_IDLE;
            ln_last = 1'b0;
         end
      endcase
      o.pin_level = drv ? (lvl ^ ln_cfg.invert_output) : 1'b0;
      o.drive_enable = drv;
      o.ready_res = rdy;
      o.command_done = dn;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ln_cfg = '{BreakReset, MarkReset, GapReset, InvReset};
         ln_phase = PH_IDLE;
         ln_count = '0;
         ln_shift = '0;
         ln_parity = 1'b0;
         ln_last = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegBreakBits:   ln_cfg.break_bits = csr_wdata[BreakWidth-1:0];
               RegMarkingBits: ln_cfg.marking_bits = csr_wdata[MarkWidth-1:0];
               RegGapBits:     ln_cfg.gap_bits = csr_wdata[GapWidth-1:0];
               RegInvert:      ln_cfg.invert_output = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_levels.push_back(next_bit_time('{req_tuser[0], req_tuser[1],
                                                      req_tdata[6:0], req_tlast}));
      end
   end

   // request driver
   req_type tx_item;
   int tx_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (line_ticks.size() > 0) begin
            tx_item = line_ticks.pop_front();
            req_tdata <= {1'b0, tx_item.char_value};
            req_tuser <= {tx_item.char_valid, tx_item.wake_request};
            req_tlast <= tx_item.last_char;
            req_tvalid <= 1'b1;
            if (tx_idle_on && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls plus a long hold-off on request
   int rx_stall = 0;
   int hold_left = 0;
   int hold_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen++;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         rsp_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
         rx_stall = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   rsp_type want;
   rsp_type got;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], rsp_tlast};
         results_seen++;
         if (expected_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: unexpected, actual pin/drv/rdy/done %b", results_seen, got);
         end else begin
            want = expected_levels.pop_front();
            if (got.pin_level !== want.pin_level || got.drive_enable !== want.drive_enable ||
                got.ready_res !== want.ready_res || got.command_done !== want.command_done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: pin/drv/rdy/done expected %b actual %b",
                           results_seen, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add_tick(bit w, bit v, logic [6:0] c, bit l);
      line_ticks.push_back('{w, v, c, l});
   endtask

   task automatic add_random_ticks(int n, int wake_pct, int last_pct);
      repeat (n)
         add_tick($urandom_range(0, 99) < wake_pct, $urandom_range(0, 99) < 85,
                  7'($urandom_range(0, 127)), $urandom_range(0, 99) < last_pct);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (line_ticks.size() != 0 || req_tvalid || expected_levels.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   // writes break, marking, gap and invert in index order; raw 5-bit words
   task automatic set_config(logic [4:0] brk, logic [4:0] mrk, logic [4:0] gap, logic [4:0] inv);
      logic [4:0] vals[4];
      vals = '{brk, mrk, gap, inv};
      for (int i = 0; i < 4; i++) begin
         csr_index <= i[CsrIdxWidth-1:0];
         csr_wdata <= vals[i];
         csr_valid <= 1'b1;
         do @(posedge clock);
         while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // zero lengths act as one, no gap, direct polarity
      set_config(5'd0, 5'd0, 5'd0, 5'd0);
      add_tick(0, 1, 7'h7F, 1);             // character while idle
      add_tick(1, 1, 7'h55, 1);             // wake, character ignored
      add_tick(1, 1, 7'h2A, 0);             // wake while busy
      add_tick(0, 1, 7'h7F, 0);             // first character
      repeat (9) add_tick(1, 1, 7'h00, 1);  // busy: wake and last flag ignored
      add_tick(0, 0, 7'h00, 0);             // waiting holds marking
      add_tick(0, 1, 7'h00, 1);             // final character
      repeat (10) add_tick(0, 0, 7'h7F, 0);
      add_tick(1, 1, 7'h7F, 1);             // wake during release
      add_tick(0, 0, 7'h00, 0);
      wait_drained();

      set_config(5'd31, 5'd15, 5'd3, 5'd1);
      add_random_ticks(100, 30, 20);
      wait_drained();

      // long receiver hold-off with the sender pushing steadily
      set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      tx_idle_on = 1'b0;
      hold_reqs++;
      add_random_ticks(120, 30, 20);
      wait_drained();
      tx_idle_on = 1'b1;

      set_config(5'd1, 5'd1, 5'd1, 5'd0);
      add_random_ticks(120, 25, 25);
      wait_drained();

      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_config(5'($urandom_range(1, 8)), 5'($urandom_range(1, 6)),
                 5'($urandom_range(0, 3)), 5'($urandom_range(0, 1)));
      add_random_ticks(100, 30, 20);
      wait_drained();

      if (mismatches == 0 && expected_levels.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
